[src/fspa_pkg.sv]
// Shared types and constants for the fixed-slot pool allocator.
`default_nettype none
package fspa_pkg;

  localparam int SlotW  = 10;
  localparam int CountW = 11;
  localparam int ObjW   = 16;
  localparam int AddrW  = 48;
  localparam int ProdW  = SlotW + ObjW;
  localparam int PaddrW = 5;
  localparam int DataW  = 64;

  localparam int MaxSlotsN = 1024;
  localparam logic [CountW-1:0] MaxSlots = CountW'(MaxSlotsN);

  // reset values of the configuration registers
  localparam logic [CountW-1:0] SlotCountRst  = CountW'(1024);
  localparam logic [ObjW-1:0]   ObjectBytesRst = ObjW'(64);
  localparam logic [AddrW-1:0]  BaseAddrRst    = '0;

  // register indexes, taken from paddr[4:3]
  localparam logic [1:0] RegSlotCount   = 2'd0;
  localparam logic [1:0] RegObjectBytes = 2'd1;
  localparam logic [1:0] RegBaseAddress = 2'd2;

  typedef enum logic {
    FUNC_ALLOC   = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_INVALID = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic             func;
    logic [SlotW-1:0] release_slot;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SlotW-1:0]  granted_slot;
    logic [AddrW-1:0]  object_address;
    logic [CountW-1:0] free_slots;
  } out_item_t;

  typedef struct packed {
    logic [CountW-1:0] eff_count;
    logic [ObjW-1:0]   object_bytes;
    logic [AddrW-1:0]  base_address;
    logic              rebuild;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } dp_stat_t;

endpackage
`default_nettype wire

[src/fspa_cfg.sv]
// Configuration register file with its APB-style port.
`default_nettype none
module fspa_cfg
  import fspa_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [DataW-1:0]  pwdata,
  output logic      [DataW-1:0]  prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  logic [CountW-1:0] slot_count_q;
  logic [ObjW-1:0]   object_bytes_q;
  logic [AddrW-1:0]  base_address_q;
  logic              rebuild_q;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q   <= SlotCountRst;
      object_bytes_q <= ObjectBytesRst;
      base_address_q <= BaseAddrRst;
      rebuild_q      <= 1'b0;
    end else begin
      // rebuild runs in the cycle after the write, against the new count
      rebuild_q <= 1'b0;
      if (wr_en) begin
        unique case (reg_idx)
          RegSlotCount: begin
            slot_count_q <= pwdata[CountW-1:0];
            rebuild_q    <= 1'b1;
          end
          RegObjectBytes: object_bytes_q <= pwdata[ObjW-1:0];
          RegBaseAddress: base_address_q <= pwdata[AddrW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegSlotCount:   prdata = {{(DataW-CountW){1'b0}}, slot_count_q};
      RegObjectBytes: prdata = {{(DataW-ObjW){1'b0}}, object_bytes_q};
      RegBaseAddress: prdata = {{(DataW-AddrW){1'b0}}, base_address_q};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o.eff_count    = (slot_count_q > MaxSlots) ? MaxSlots : slot_count_q;
  assign cfg_o.object_bytes = object_bytes_q;
  assign cfg_o.base_address = base_address_q;
  assign cfg_o.rebuild      = rebuild_q;

endmodule
`default_nettype wire

[src/fspa_ctrl.sv]
// Sequencer: accept, execute, finish for one item at a time.
`default_nettype none
module fspa_ctrl
  import fspa_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire dp_stat_t stat_i,
  output ctrl_cmd_t     cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_stall_o   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_FINISH;
      end
      ST_FINISH: begin
        // wait here while the previous result sits stalled in the output register
        if (!stat_i.out_blocked) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[src/fspa_dp.sv]
// Datapath: free-list head, link and taken memories, address and output register.
`default_nettype none
module fspa_dp
  import fspa_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire ctrl_cmd_t cmd_i,
  output dp_stat_t       stat_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  // Slots at or above fill_q have not been handed out since the last rebuild:
  // their link is the implicit successor and they read as free, so the
  // memories never need clearing.
  logic [SlotW-1:0]  link_mem [MaxSlotsN];
  logic              taken_mem [MaxSlotsN];

  logic [SlotW-1:0]  head_q;
  logic [CountW-1:0] fill_q;
  logic [CountW-1:0] free_q;
  in_item_t          item_q;
  logic [SlotW-1:0]  link_rd_q;
  logic              taken_rd_q;
  logic [ProdW-1:0]  prod_q;
  logic [SlotW-1:0]  grant_slot_q;
  logic              grant_q;
  status_e           status_q;
  out_item_t         out_q;
  logic              out_valid_q;

  logic              is_alloc;
  logic              fresh;
  logic [CountW-1:0] head_inc;
  logic [SlotW-1:0]  next_head;
  logic              alloc_ok;
  logic              rel_ok;
  logic [CountW-1:0] rel_ext;
  logic [AddrW-1:0]  addr;

  assign is_alloc = (item_q.func == FUNC_ALLOC);
  assign fresh    = ({1'b0, head_q} >= fill_q);
  assign head_inc = {1'b0, head_q} + CountW'(1);
  assign alloc_ok = is_alloc && (free_q != '0);
  assign rel_ext  = {1'b0, item_q.release_slot};
  assign rel_ok   = !is_alloc && (rel_ext < cfg_i.eff_count) && (rel_ext < fill_q)
                    && taken_rd_q;

  always_comb begin
    if (fresh) begin
      next_head = (head_inc < cfg_i.eff_count) ? head_inc[SlotW-1:0] : '0;
    end else begin
      next_head = link_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      link_rd_q <= link_mem[head_q];
    end
    if (cmd_i.exec && rel_ok) begin
      link_mem[item_q.release_slot] <= head_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      taken_rd_q <= taken_mem[in_item_i.release_slot];
    end
    if (cmd_i.exec && alloc_ok) begin
      taken_mem[head_q] <= 1'b1;
    end else if (cmd_i.exec && rel_ok) begin
      taken_mem[item_q.release_slot] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
      free_q <= MaxSlots;
    end else if (cfg_i.rebuild) begin
      head_q <= '0;
      fill_q <= '0;
      free_q <= cfg_i.eff_count;
    end else if (cmd_i.exec) begin
      if (alloc_ok) begin
        head_q <= next_head;
        free_q <= free_q - CountW'(1);
        if (fresh) begin
          fill_q <= fill_q + CountW'(1);
        end
      end else if (rel_ok) begin
        head_q <= item_q.release_slot;
        free_q <= free_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_item_i;
    end
    if (cmd_i.exec) begin
      grant_q      <= alloc_ok;
      grant_slot_q <= alloc_ok ? head_q : '0;
      prod_q       <= alloc_ok ? ProdW'(head_q) * ProdW'(cfg_i.object_bytes) : '0;
      if (is_alloc) begin
        status_q <= alloc_ok ? STAT_OK : STAT_EMPTY;
      end else begin
        status_q <= rel_ok ? STAT_OK : STAT_INVALID;
      end
    end
  end

  assign addr = grant_q ? (cfg_i.base_address + {{(AddrW-ProdW){1'b0}}, prod_q}) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.status         <= status_q;
      out_q.granted_slot   <= grant_slot_q;
      out_q.object_address <= addr;
      out_q.free_slots     <= free_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.out_blocked = out_valid_q && out_stall_i;
  assign out_valid_o        = out_valid_q;
  assign out_item_o         = out_q;

`ifndef SYNTHESIS
  // a new count is already visible while rebuild is high, before the rebuild applies it
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_i.rebuild |-> free_q <= cfg_i.eff_count)
    else $error("free count exceeds slot count");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_i.rebuild |-> fill_q <= cfg_i.eff_count)
    else $error("fresh-slot mark exceeds slot count");

  a_alloc_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && alloc_ok && !cfg_i.rebuild |=> free_q == $past(free_q) - CountW'(1))
    else $error("grant did not take a slot off the free count");

  a_rel_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && rel_ok && !cfg_i.rebuild |=> head_q == $past(item_q.release_slot))
    else $error("released slot not pushed on the list head");
`endif

endmodule
`default_nettype wire

[src/fixed_slot_pool_allocator_top.sv]
// Fixed-size object pool allocator: LIFO free list of slot indices.
//
// Input channel in_valid_i/in_stall_o carries one item: func selects allocate
// or release, release_slot names the slot to give back. Output channel
// out_valid_o/out_stall_i returns one result item per input item: status,
// granted slot, its address (base + slot * object size, 48-bit wrap) and the
// free count after the operation.
// Sequence: an item is accepted in IDLE, executed in EXEC and its result is
// loaded into the output register in FINISH; the next item is accepted only
// back in IDLE. The steps are the synchronous read of the link and taken
// memories, then the slot * size multiply, then the base add.
// A result stalled by the receiver holds in the output register; the block
// still takes the next item and holds that one's result until the register frees.
// Reset: 1024 slots of 64 bytes at base 0, every slot free. Writing slot_count
// rebuilds the list 0..count-1, count capped at 1024; memories need no clearing
// pass, a fresh-slot mark stands in for their reset contents.
// Configuration: APB-style, 64-bit data, register i at byte address 8*i.
`default_nettype none
module fixed_slot_pool_allocator_top
  import fspa_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire in_item_t          in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_item_t              out_item_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [DataW-1:0]  pwdata,
  output logic      [DataW-1:0]  prdata,
  output logic                   pready
);

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  fspa_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fspa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fspa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire
